/* hw/rtl/length_framed_byte_deframer_macros.svh */
// length_framed_byte_deframer_macros.svh
// Assertion macros used by the deframer top level; no other dependencies.
`ifndef LENGTH_FRAMED_BYTE_DEFRAMER_MACROS_SVH
`define LENGTH_FRAMED_BYTE_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");

`endif

/* hw/rtl/ldf_pkg.sv */
// ldf_pkg.sv
// Shared constants, types and helpers for the length-framed byte deframer.
// No dependencies; imported by every deframer module.
package ldf_pkg;

    localparam int MaxPayload = 32;
    localparam int StoreDepth = 64;
    localparam int OutCap     = MaxPayload + 2;

    localparam int AW    = $clog2(StoreDepth);
    localparam int LenW  = $clog2(MaxPayload + 1);
    localparam int EcW   = $clog2(MaxPayload + 2);
    localparam int CntW  = $clog2(OutCap + 1);
    localparam int SeenW = 7;

    localparam logic [7:0] HDR0 = 8'hEB;
    localparam logic [7:0] HDR1 = 8'h09;
    localparam logic [7:0] TRL0 = 8'h0D;
    localparam logic [7:0] TRL1 = 8'h0A;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRAILER = 2'd1;
    localparam logic [1:0] ST_LENGTH  = 2'd2;

    // Frame parser phase.
    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_HDR1 = 7'b0000010,
        PH_ID   = 7'b0000100,
        PH_LEN  = 7'b0001000,
        PH_PAY  = 7'b0010000,
        PH_TRL0 = 7'b0100000,
        PH_TRL1 = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic       last;
        logic [1:0] status;
        logic [7:0] data;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic accept;      // write input byte and parse it
        logic fetch;       // read store at replay pointer
        logic parse;       // parse the fetched byte
        logic emit_fetch;  // read store at emit index
        logic emit_push;   // push the fetched frame byte
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic fault;      // parse of current byte faults
        logic frame_ok;   // parse of current byte completes a frame
        logic more;       // bytes left to parse after current byte
        logic pending;    // bytes left to parse now
        logic emit_last;  // fetched frame byte is the last of the frame
    } t_stat;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        if (idx == AW'(StoreDepth - 1)) begin
            return '0;
        end
        return AW'(idx + 1'b1);
    endfunction

endpackage

/* hw/rtl/ldf_ofifo.sv */
// ldf_ofifo.sv
// Two-entry result queue in front of the master port.
// Depends on ldf_pkg for the result type.
module ldf_ofifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ldf_pkg::t_result i_data,
    output logic            o_room,
    output logic            o_valid,
    output ldf_pkg::t_result o_data,
    input  logic            i_ready
);
    import ldf_pkg::*;

    t_result    r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    always_comb begin
        o_valid = (r_cnt != 2'd0);
        o_room  = !r_cnt[1];
        o_data  = r_q[r_rd];
        pop     = o_valid && i_ready;
        n_wr    = i_push ? !r_wr : r_wr;
        n_rd    = pop ? !r_rd : r_rd;
        n_cnt   = 2'(r_cnt + 2'(i_push) - 2'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hw/rtl/ldf_dpath.sv */
// ldf_dpath.sv
// Deframer datapath: byte store ring, pointers, frame parser and result build.
// Depends on ldf_pkg; driven by ldf_ctrl.
module ldf_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ldf_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_in_byte,
    output ldf_pkg::t_stat   o_stat,
    output logic             o_push,
    output ldf_pkg::t_result o_result
);
    import ldf_pkg::*;

    logic [7:0]      r_mem [StoreDepth];
    logic [7:0]      r_rd;
    logic [AW-1:0]   r_tail, n_tail;
    logic [AW-1:0]   r_rp, n_rp;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_eidx, n_eidx;
    t_phase          r_phase, n_phase;
    logic [LenW-1:0] r_len, n_len;
    logic [SeenW-1:0] r_seen, n_seen;
    logic [EcW-1:0]  r_ecnt, n_ecnt;
    logic [CntW-1:0] r_step, n_step;

    logic             caught_up;
    logic             parse_en;
    logic [7:0]       pb;
    logic [AW-1:0]    rp_adv;
    logic [AW-1:0]    tail_after;
    logic [AW-1:0]    rd_addr;
    logic [SeenW-1:0] seen_inc;
    logic [SeenW-1:0] len_plus2;
    logic             emit_last;
    logic             push_req;
    logic [CntW-1:0]  step_base;

    // Parser outcome for the byte at hand; applied only when parsing.
    t_phase           p_phase;
    logic [AW-1:0]    p_head;
    logic [LenW-1:0]  p_len;
    logic [SeenW-1:0] p_seen;
    logic             p_fault;
    logic [1:0]       p_fault_st;
    logic             p_frame_ok;

    always_comb begin
        // When caught up, the byte to parse is the one arriving now.
        caught_up  = (r_rp == r_tail);
        parse_en   = i_cmd.accept || i_cmd.parse;
        pb         = caught_up ? i_in_byte : r_rd;
        rp_adv     = ring_next(r_rp);
        tail_after = caught_up ? ring_next(r_tail) : r_tail;
        seen_inc   = SeenW'(r_seen + SeenW'(1));
        len_plus2  = SeenW'(SeenW'(r_len) + SeenW'(2));
    end

    always_comb begin
        p_phase    = r_phase;
        p_head     = r_head;
        p_len      = r_len;
        p_seen     = r_seen;
        p_fault    = 1'b0;
        p_fault_st = ST_OK;
        p_frame_ok = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (pb == HDR0) begin
                    p_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                if (pb == HDR1) begin
                    p_phase = PH_ID;
                    p_head  = rp_adv;
                    p_seen  = '0;
                end else if (pb != HDR0) begin
                    p_phase = PH_HUNT;
                end
            end
            PH_ID: begin
                p_seen  = SeenW'(1);
                p_phase = PH_LEN;
            end
            PH_LEN: begin
                p_seen = SeenW'(2);
                if (pb > 8'(MaxPayload)) begin
                    p_fault    = 1'b1;
                    p_fault_st = ST_LENGTH;
                    p_phase    = PH_HUNT;
                end else begin
                    p_len   = LenW'(pb);
                    p_phase = (pb != 8'd0) ? PH_PAY : PH_TRL0;
                end
            end
            PH_PAY: begin
                p_seen = seen_inc;
                if (seen_inc >= len_plus2) begin
                    p_phase = PH_TRL0;
                end
            end
            PH_TRL0: begin
                p_seen = seen_inc;
                if (pb == TRL0) begin
                    p_phase = PH_TRL1;
                end else begin
                    p_fault    = 1'b1;
                    p_fault_st = ST_TRAILER;
                    p_phase    = PH_HUNT;
                end
            end
            PH_TRL1: begin
                p_seen  = seen_inc;
                p_phase = PH_HUNT;
                if (pb == TRL1) begin
                    p_frame_ok = 1'b1;
                end else begin
                    p_fault    = 1'b1;
                    p_fault_st = ST_TRAILER;
                end
            end
            default: begin
                p_phase = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        n_phase = parse_en ? p_phase : r_phase;
        n_head  = parse_en ? p_head : r_head;
        n_len   = parse_en ? p_len : r_len;
        n_seen  = parse_en ? p_seen : r_seen;
        n_tail  = i_cmd.accept ? ring_next(r_tail) : r_tail;

        // Rewind to the byte after the header on a fault.
        n_rp = r_rp;
        if (parse_en) begin
            n_rp = p_fault ? r_head : rp_adv;
        end

        emit_last = (r_ecnt == EcW'(EcW'(r_len) + EcW'(1)));
        n_eidx    = r_eidx;
        n_ecnt    = r_ecnt;
        if (parse_en && p_frame_ok) begin
            n_eidx = r_head;
            n_ecnt = '0;
        end else if (i_cmd.emit_push) begin
            n_eidx = ring_next(r_eidx);
            n_ecnt = EcW'(r_ecnt + EcW'(1));
        end

        // Results beyond the per-input cap are dropped.
        step_base = i_cmd.accept ? '0 : r_step;
        push_req  = (parse_en && p_fault) || i_cmd.emit_push;
        o_push    = push_req && (step_base < CntW'(OutCap));
        n_step    = CntW'(step_base + CntW'(o_push));

        if (i_cmd.emit_push) begin
            o_result.data   = r_rd;
            o_result.status = ST_OK;
            o_result.last   = emit_last;
        end else begin
            o_result.data   = 8'd0;
            o_result.status = p_fault_st;
            o_result.last   = 1'b1;
        end

        o_stat.fault     = p_fault;
        o_stat.frame_ok  = p_frame_ok;
        o_stat.more      = p_fault ? (r_head != tail_after) : (rp_adv != tail_after);
        o_stat.pending   = !caught_up;
        o_stat.emit_last = emit_last;

        rd_addr = i_cmd.emit_fetch ? r_eidx : r_rp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_tail] <= i_in_byte;
        end
        if (i_cmd.fetch || i_cmd.emit_fetch) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail  <= '0;
            r_rp    <= '0;
            r_head  <= '0;
            r_eidx  <= '0;
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_seen  <= '0;
            r_ecnt  <= '0;
            r_step  <= '0;
        end else begin
            r_tail  <= n_tail;
            r_rp    <= n_rp;
            r_head  <= n_head;
            r_eidx  <= n_eidx;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_ecnt  <= n_ecnt;
            r_step  <= n_step;
        end
    end

endmodule

/* hw/rtl/ldf_ctrl.sv */
// ldf_ctrl.sv
// Deframer controller: sequences input accept, store replay and frame output.
// Depends on ldf_pkg for the command and status structs.
module ldf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  logic           i_room,
    input  ldf_pkg::t_stat i_stat,
    output ldf_pkg::t_cmd  o_cmd
);
    import ldf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_FETCH   = 5'b00010,
        S_PARSE   = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = i_room;
                if (i_s_valid && i_room) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.frame_ok) begin
                        n_state = S_EMIT_RD;
                    end else if (i_stat.more) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_PARSE;
            end
            S_PARSE: begin
                // hold until a fault result would have a slot
                if (i_room) begin
                    o_cmd.parse = 1'b1;
                    if (i_stat.frame_ok) begin
                        n_state = S_EMIT_RD;
                    end else if (i_stat.more) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_RD: begin
                o_cmd.emit_fetch = 1'b1;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (i_room) begin
                    o_cmd.emit_push = 1'b1;
                    if (!i_stat.emit_last) begin
                        n_state = S_EMIT_RD;
                    end else if (i_stat.pending) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/length_framed_byte_deframer.sv */
// Length-framed byte deframer.
//
// Slave channel (i_s_*): one received link byte per request in tdata.
// Master channel (o_m_*): results. tdata carries the frame byte (id, then
// length, then payload; zero on a fault), tuser the status (0 frame byte,
// 1 trailer mismatch, 2 length over limit), tlast marks the end of a run.
// A fault is a run of one result.
// Bytes before the header EB 09 are dropped. A good frame (id, length,
// payload, trailer 0D 0A) comes out as length + 2 results; a bad one gives
// one fault result, and all bytes after its header are parsed again.
// Throughput: one input byte per cycle while no frame ends and no fault
// occurs. Replayed bytes and frame results each need a read of the 64-byte
// store ring, which has a single read port, before they are parsed or pushed.
// After the last trailer byte, the first result is read, queued and output.
// A two-entry result queue lets input continue while a result waits; when
// the receiver stalls and the queue fills, tready drops.
// Reset (synchronous, active low) returns the parser to header hunt and
// empties the store ring and result queue; no clearing pass is needed.
`include "length_framed_byte_deframer_macros.svh"

module length_framed_byte_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_tuser,   // [1:0] status
    output logic       o_m_tlast
);
    import ldf_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;
    t_result w_out;
    logic    w_push;
    logic    w_room;
    logic    w_m_fault;

    ldf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .o_s_ready (o_s_tready),
        .i_room    (w_room),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ldf_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_in_byte (i_s_tdata),
        .o_stat    (w_stat),
        .o_push    (w_push),
        .o_result  (w_res)
    );

    ldf_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = w_out.data;
    assign o_m_tuser = w_out.status;
    assign o_m_tlast = w_out.last;
    assign w_m_fault = o_m_tvalid && (o_m_tuser != ST_OK);

    `LDF_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_push, w_room)
    `LDF_ASSERT_NEXT(a_no_accept_after_fetch, i_clk, i_rst_n, w_cmd.fetch, !o_s_tready)
    `LDF_ASSERT_NOW(a_fault_is_single, i_clk, i_rst_n, w_m_fault, o_m_tlast && o_m_tdata == 8'd0)

endmodule
